[hw/rtl/lbe_pkg.sv]
// lbe_pkg: widths, control bit positions and shared structs for the load buffer entry
// used by lbe_core, lbe_out_reg and tomasulo_load_buffer_entry; no dependencies
package lbe_pkg;

    localparam int DATA_BITS    = 32;
    localparam int TAG_BITS     = 5;
    localparam int OP_BITS      = 8;
    localparam int CTL_BITS     = 4;
    localparam int LOOKUP_BITS  = TAG_BITS + 2;
    localparam int BUS_BITS     = DATA_BITS + TAG_BITS + 1;

    localparam int CTL_FLUSH    = 0;
    localparam int CTL_FREE     = 1;
    localparam int CTL_ALLOC    = 2;
    localparam int CTL_STALL    = 3;

    localparam int LOOK_PENDING = TAG_BITS + 1;
    localparam int LOOK_READY   = TAG_BITS;
    localparam int BUS_VALID    = DATA_BITS + TAG_BITS;
    localparam int MEM_DONE     = DATA_BITS;
    localparam int AGU_DONE     = DATA_BITS + 1;
    localparam int AGU_FAULT    = DATA_BITS;

    typedef struct packed {
        logic                 busy;
        logic [OP_BITS-1:0]   op_code;
        logic [DATA_BITS-1:0] base_value;
        logic [TAG_BITS-1:0]  base_wait_tag;
        logic                 base_waiting;
        logic [DATA_BITS-1:0] offset_value;
        logic [DATA_BITS-1:0] eff_address;
        logic                 address_ready;
        logic [DATA_BITS-1:0] load_data;
        logic                 load_done;
        logic [TAG_BITS-1:0]  rob_dest;
        logic                 seg_fault;
        logic                 result_sent;
    } entry_t;

    typedef struct packed {
        logic                 busy_res;
        logic                 agu_request;
        logic [DATA_BITS-1:0] agu_base;
        logic [DATA_BITS-1:0] agu_offset;
        logic                 mem_request;
        logic [DATA_BITS-1:0] mem_address;
        logic [OP_BITS-1:0]   mem_op;
        logic                 result_request;
        logic [DATA_BITS-1:0] result_value;
        logic                 result_exception;
        logic [TAG_BITS-1:0]  dest_tag;
    } result_t;

endpackage

[hw/rtl/tomasulo_load_buffer_entry.sv]
// tomasulo_load_buffer_entry: top level of one load buffer slot
// depends on lbe_pkg, lbe_core, lbe_out_reg
//
//  port group | dir | handshake          | carries
//  s_*        | in  | s_valid / s_ready  | one cycle of control and bus signals
//  m_*        | out | m_valid / m_ready  | the requests seen before that cycle's update
//
// one transfer per clock while s_ready is high; the result appears in the cycle after its input transfer
// s_ready is low only while the result register is full and m_ready is low
// aresetn clears the whole entry state and the result valid flag
module tomasulo_load_buffer_entry (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lbe_pkg::CTL_BITS-1:0]         s_control,
    input  logic [lbe_pkg::OP_BITS-1:0]          s_alloc_op,
    input  logic signed [lbe_pkg::DATA_BITS-1:0] s_alloc_offset,
    input  logic [lbe_pkg::TAG_BITS-1:0]         s_alloc_rob_tag,
    input  logic [lbe_pkg::LOOKUP_BITS-1:0]      s_base_lookup,
    input  logic [2*lbe_pkg::DATA_BITS-1:0]      s_base_values,
    input  logic [lbe_pkg::BUS_BITS-1:0]         s_bus_a,
    input  logic [lbe_pkg::BUS_BITS-1:0]         s_bus_b,
    input  logic [lbe_pkg::DATA_BITS:0]          s_mem_response,
    input  logic [lbe_pkg::DATA_BITS+1:0]        s_agu_response,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_busy_res,
    output logic                                 m_agu_request,
    output logic [lbe_pkg::DATA_BITS-1:0]        m_agu_base,
    output logic signed [lbe_pkg::DATA_BITS-1:0] m_agu_offset,
    output logic                                 m_mem_request,
    output logic [lbe_pkg::DATA_BITS-1:0]        m_mem_address,
    output logic [lbe_pkg::OP_BITS-1:0]          m_mem_op,
    output logic                                 m_result_request,
    output logic [lbe_pkg::DATA_BITS-1:0]        m_result_value,
    output logic                                 m_result_exception,
    output logic [lbe_pkg::TAG_BITS-1:0]         m_dest_tag
);

    logic             xfer;
    logic             take_ok;
    lbe_pkg::result_t core_res;
    lbe_pkg::result_t out_res;

    assign s_ready = take_ok;
    assign xfer    = s_valid && take_ok;

    lbe_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (xfer),
        .control       (s_control),
        .alloc_op      (s_alloc_op),
        .alloc_offset  (s_alloc_offset),
        .alloc_rob_tag (s_alloc_rob_tag),
        .base_lookup   (s_base_lookup),
        .base_values   (s_base_values),
        .bus_a         (s_bus_a),
        .bus_b         (s_bus_b),
        .mem_response  (s_mem_response),
        .agu_response  (s_agu_response),
        .result        (core_res)
    );

    lbe_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (xfer),
        .data_in  (core_res),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .take_ok  (take_ok),
        .data_out (out_res)
    );

    assign m_busy_res         = out_res.busy_res;
    assign m_agu_request      = out_res.agu_request;
    assign m_agu_base         = out_res.agu_base;
    assign m_agu_offset       = $signed(out_res.agu_offset);
    assign m_mem_request      = out_res.mem_request;
    assign m_mem_address      = out_res.mem_address;
    assign m_mem_op           = out_res.mem_op;
    assign m_result_request   = out_res.result_request;
    assign m_result_value     = out_res.result_value;
    assign m_result_exception = out_res.result_exception;
    assign m_dest_tag         = out_res.dest_tag;

endmodule

[hw/rtl/lbe_core.sv]
// lbe_core: entry state registers, request outputs and per-transfer state update
// depends on lbe_pkg
module lbe_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step,
    input  logic [lbe_pkg::CTL_BITS-1:0]       control,
    input  logic [lbe_pkg::OP_BITS-1:0]        alloc_op,
    input  logic signed [lbe_pkg::DATA_BITS-1:0] alloc_offset,
    input  logic [lbe_pkg::TAG_BITS-1:0]       alloc_rob_tag,
    input  logic [lbe_pkg::LOOKUP_BITS-1:0]    base_lookup,
    input  logic [2*lbe_pkg::DATA_BITS-1:0]    base_values,
    input  logic [lbe_pkg::BUS_BITS-1:0]       bus_a,
    input  logic [lbe_pkg::BUS_BITS-1:0]       bus_b,
    input  logic [lbe_pkg::DATA_BITS:0]        mem_response,
    input  logic [lbe_pkg::DATA_BITS+1:0]      agu_response,
    output lbe_pkg::result_t                   result
);

    lbe_pkg::entry_t ent_reg;
    lbe_pkg::entry_t ent_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '0;
        end else if (step) begin
            ent_reg <= ent_next;
        end
    end

    always_comb begin
        result.busy_res       = ent_reg.busy;
        result.agu_request    = ent_reg.busy && !ent_reg.base_waiting && !ent_reg.address_ready;
        result.agu_base       = ent_reg.base_value;
        result.agu_offset     = ent_reg.offset_value;
        result.mem_request    = ent_reg.busy && ent_reg.address_ready && !ent_reg.seg_fault
                                && !ent_reg.load_done;
        result.mem_address    = ent_reg.eff_address;
        result.mem_op         = ent_reg.op_code;
        result.dest_tag       = ent_reg.rob_dest;
        if (ent_reg.seg_fault) begin
            result.result_request   = ent_reg.busy && ent_reg.address_ready
                                      && !ent_reg.result_sent;
            result.result_value     = '0;
            result.result_exception = 1'b1;
        end else begin
            result.result_request   = ent_reg.busy && ent_reg.load_done && !ent_reg.result_sent;
            result.result_value     = ent_reg.load_data;
            result.result_exception = 1'b0;
        end
    end

    always_comb begin
        ent_next = ent_reg;
        if (control[lbe_pkg::CTL_FLUSH] || control[lbe_pkg::CTL_FREE]) begin
            ent_next.busy = 1'b0;
        end else begin
            if (control[lbe_pkg::CTL_ALLOC] && !ent_reg.busy) begin
                ent_next.busy          = 1'b1;
                ent_next.op_code       = alloc_op;
                ent_next.offset_value  = alloc_offset;
                ent_next.rob_dest      = alloc_rob_tag;
                ent_next.address_ready = 1'b0;
                ent_next.seg_fault     = 1'b0;
                ent_next.load_done     = 1'b0;
                ent_next.result_sent   = 1'b0;
                if (!base_lookup[lbe_pkg::LOOK_PENDING]) begin
                    ent_next.base_value   = base_values[lbe_pkg::DATA_BITS-1:0];
                    ent_next.base_waiting = 1'b0;
                end else if (base_lookup[lbe_pkg::LOOK_READY]) begin
                    ent_next.base_value   = base_values[2*lbe_pkg::DATA_BITS-1:lbe_pkg::DATA_BITS];
                    ent_next.base_waiting = 1'b0;
                end else begin
                    ent_next.base_wait_tag = base_lookup[lbe_pkg::TAG_BITS-1:0];
                    ent_next.base_waiting  = 1'b1;
                end
            end
            // bus a first so it wins on a double match
            if (ent_next.busy && ent_next.base_waiting && bus_a[lbe_pkg::BUS_VALID]
                && bus_a[lbe_pkg::BUS_VALID-1:lbe_pkg::DATA_BITS] == ent_next.base_wait_tag) begin
                ent_next.base_value   = bus_a[lbe_pkg::DATA_BITS-1:0];
                ent_next.base_waiting = 1'b0;
            end
            if (ent_next.busy && ent_next.base_waiting && bus_b[lbe_pkg::BUS_VALID]
                && bus_b[lbe_pkg::BUS_VALID-1:lbe_pkg::DATA_BITS] == ent_next.base_wait_tag) begin
                ent_next.base_value   = bus_b[lbe_pkg::DATA_BITS-1:0];
                ent_next.base_waiting = 1'b0;
            end
            if (ent_next.busy && (ent_next.load_done || ent_next.seg_fault)) begin
                ent_next.result_sent = 1'b1;
            end
            if (ent_next.busy && mem_response[lbe_pkg::MEM_DONE]) begin
                ent_next.load_data = mem_response[lbe_pkg::DATA_BITS-1:0];
                ent_next.load_done = 1'b1;
            end
            if (ent_next.busy && control[lbe_pkg::CTL_STALL]) begin
                ent_next.result_sent = 1'b0;
            end
            if (ent_next.busy && agu_response[lbe_pkg::AGU_DONE]) begin
                ent_next.eff_address   = agu_response[lbe_pkg::DATA_BITS-1:0];
                ent_next.address_ready = 1'b1;
                ent_next.seg_fault     = agu_response[lbe_pkg::AGU_FAULT];
            end
        end
    end

endmodule

[hw/rtl/lbe_out_reg.sv]
// lbe_out_reg: result register with valid/ready handshake toward the consumer
// depends on lbe_pkg
module lbe_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  lbe_pkg::result_t data_in,
    input  logic             m_ready,
    output logic             m_valid,
    output logic             take_ok,
    output lbe_pkg::result_t data_out
);

    logic             valid_reg;
    logic             valid_next;
    lbe_pkg::result_t data_reg;

    assign take_ok = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_in;
        end
    end

    assign m_valid  = valid_reg;
    assign data_out = data_reg;

endmodule
